// ===== rtl/irb_pkg.sv =====
// Package for the idle-drained receive ring buffer.
// Sizes, input codes, controller states and the control/status structs.
// No dependencies.
package irb_pkg;

    localparam int BUF_DEPTH = 256;
    localparam int MAX_READ  = 64;
    localparam int PTR_W     = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int LEN_W     = 7;
    localparam int BYTE_W    = 8;
    localparam int FUNC_W    = 2;
    localparam int S_DATA_W  = 16;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [LEN_W-1:0] len_t;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_RX_BYTE = 2'd0,
        FUNC_IDLE    = 2'd1,
        FUNC_READ    = 2'd2,
        FUNC_NONE    = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_READ_RD,
        ST_READ_OUT,
        ST_EMPTY
    } state_t;

    typedef struct packed {
        logic rx_wr;
        logic drain_step;
        logic read_start;
        logic read_step;
    } irb_cmd_t;

    typedef struct packed {
        logic drain_busy;
        logic read_none;
        logic last;
    } irb_status_t;

    function automatic ptr_t ptr_inc(input ptr_t p);
        ptr_t r;
        if (p == PTR_W'(BUF_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + ptr_t'(1);
        end
        return r;
    endfunction

endpackage

// ===== rtl/irb_dp.sv =====
// Datapath: landing store, drain pipeline, ring FIFO and read-out registers.
// Driven by irb_ctrl commands; depends on irb_pkg.
module irb_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  irb_pkg::irb_cmd_t              cmd,
    input  logic [irb_pkg::BYTE_W-1:0]     rx_byte,
    input  logic [irb_pkg::LEN_W-1:0]      max_len,
    output irb_pkg::irb_status_t           status,
    output logic [irb_pkg::BYTE_W-1:0]     rd_byte
);
    import irb_pkg::*;

    logic [BYTE_W-1:0] landing_mem [BUF_DEPTH];
    logic [BYTE_W-1:0] fifo_mem    [BUF_DEPTH];

    ptr_t wpos_reg, wpos_next;
    ptr_t dpos_reg, dpos_next;
    ptr_t head_reg, head_next;
    ptr_t tail_reg, tail_next;
    logic pipe_reg, pipe_next;
    len_t len_reg,  len_next;
    len_t cnt_reg,  cnt_next;
    logic last_reg, last_next;

    logic [BYTE_W-1:0] land_rd_reg;
    logic [BYTE_W-1:0] fifo_rd_reg;

    logic drain_more;
    logic fifo_full;
    logic push;

    assign drain_more = (dpos_reg != wpos_reg);
    assign fifo_full  = (ptr_inc(head_reg) == tail_reg);
    assign push       = cmd.drain_step && pipe_reg && !fifo_full;

    always_comb begin
        wpos_next = wpos_reg;
        dpos_next = dpos_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        pipe_next = pipe_reg;
        len_next  = len_reg;
        cnt_next  = cnt_reg;
        last_next = last_reg;
        if (cmd.rx_wr) begin
            wpos_next = ptr_inc(wpos_reg);
        end
        if (cmd.drain_step) begin
            pipe_next = drain_more;
            if (drain_more) begin
                dpos_next = ptr_inc(dpos_reg);
            end
            if (push) begin
                head_next = ptr_inc(head_reg);
            end
        end
        if (cmd.read_start) begin
            len_next = (max_len > LEN_W'(MAX_READ)) ? LEN_W'(MAX_READ) : max_len;
            cnt_next = '0;
        end
        if (cmd.read_step) begin
            tail_next = ptr_inc(tail_reg);
            cnt_next  = cnt_reg + len_t'(1);
            last_next = ((cnt_reg + len_t'(1)) == len_reg)
                     || (ptr_inc(tail_reg) == head_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wpos_reg <= '0;
            dpos_reg <= '0;
            head_reg <= '0;
            tail_reg <= '0;
            pipe_reg <= 1'b0;
            len_reg  <= '0;
            cnt_reg  <= '0;
            last_reg <= 1'b0;
        end else begin
            wpos_reg <= wpos_next;
            dpos_reg <= dpos_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            pipe_reg <= pipe_next;
            len_reg  <= len_next;
            cnt_reg  <= cnt_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rx_wr) begin
            landing_mem[wpos_reg] <= rx_byte;
        end
        if (cmd.drain_step && drain_more) begin
            land_rd_reg <= landing_mem[dpos_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[head_reg] <= land_rd_reg;
        end
        if (cmd.read_step) begin
            fifo_rd_reg <= fifo_mem[tail_reg];
        end
    end

    assign status.drain_busy = drain_more || pipe_reg;
    assign status.read_none  = (max_len == '0) || (head_reg == tail_reg);
    assign status.last       = last_reg;
    assign rd_byte           = fifo_rd_reg;

endmodule

// ===== rtl/irb_ctrl.sv =====
// Controller FSM: takes input beats, sequences drains and read-outs.
// Drives irb_dp through irb_cmd_t; depends on irb_pkg.
module irb_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    input  logic [irb_pkg::FUNC_W-1:0]   func,
    input  logic                         m_tready,
    input  irb_pkg::irb_status_t         status,
    output logic                         s_tready,
    output logic                         m_tvalid,
    output logic                         has_data,
    output irb_pkg::irb_cmd_t            cmd
);
    import irb_pkg::*;

    state_t state_reg, state_next;
    func_t  func_in;
    logic   accept;

    assign func_in = func_t'(func);
    assign accept  = s_tvalid && (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (func_in)
                        FUNC_IDLE: state_next = ST_DRAIN;
                        FUNC_READ: state_next = status.read_none ? ST_EMPTY : ST_READ_RD;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DRAIN: begin
                if (!status.drain_busy) begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ_RD: state_next = ST_READ_OUT;
            ST_READ_OUT: begin
                if (m_tready) begin
                    state_next = status.last ? ST_IDLE : ST_READ_RD;
                end
            end
            ST_EMPTY: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        has_data = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready       = 1'b1;
                cmd.rx_wr      = accept && (func_in == FUNC_RX_BYTE);
                cmd.read_start = accept && (func_in == FUNC_READ);
            end
            ST_DRAIN:   cmd.drain_step = 1'b1;
            ST_READ_RD: cmd.read_step  = 1'b1;
            ST_READ_OUT: begin
                m_tvalid = 1'b1;
                has_data = 1'b1;
            end
            ST_EMPTY:   m_tvalid = 1'b1;
            default:    cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/idle_drained_rx_ring_buffer.sv =====
// Idle-drained receive ring buffer, top level. Uses irb_pkg, irb_ctrl, irb_dp.
// Idle drain: one landing store read per cycle, one pipeline stage to the FIFO
// write port. Read: accepted in idle, then each beat is a registered FIFO read
// (ST_READ_RD) followed by output (ST_READ_OUT), held until m_tready; an empty
// reply is a single beat. One item at a time.
// Synchronous active-low reset clears pointers and FSM; stores are not cleared.
module idle_drained_rx_ring_buffer (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [irb_pkg::S_DATA_W-1:0]    s_tdata,   // rx_byte[7:0], max_len[14:8]
    input  logic [irb_pkg::FUNC_W-1:0]      s_tuser,   // func[1:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [irb_pkg::BYTE_W-1:0]      m_tdata,   // data_byte[7:0]
    output logic [0:0]                      m_tuser,   // has_data[0]
    output logic                            m_tlast
);
    import irb_pkg::*;

    irb_cmd_t          cmd;
    irb_status_t       status;
    logic [BYTE_W-1:0] rd_byte;
    logic              has_data;

    irb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .func     (s_tuser),
        .m_tready (m_tready),
        .status   (status),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .has_data (has_data),
        .cmd      (cmd)
    );

    irb_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .rx_byte (s_tdata[BYTE_W-1:0]),
        .max_len (s_tdata[BYTE_W+LEN_W-1:BYTE_W]),
        .status  (status),
        .rd_byte (rd_byte)
    );

    assign m_tdata    = has_data ? rd_byte : '0;
    assign m_tuser[0] = has_data;
    assign m_tlast    = has_data ? status.last : 1'b1;

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input taken while a result beat is pending");

    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tlast && (m_tdata == '0)))
        else $error("empty reply not marked last or carries data");

    a_read_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == FUNC_READ)) |=> !s_tready)
        else $error("read request did not block input");

endmodule
